[src/via_pkg.sv]
package via_pkg;

  typedef enum logic [2:0] {
    KindRead    = 3'd0,
    KindWrite   = 3'd1,
    KindTick    = 3'd2,
    KindPulse   = 3'd3,
    KindShiftIn = 3'd4,
    KindShiftOut = 3'd5,
    KindPins    = 3'd6,
    KindNone    = 3'd7
  } kind_e;

  localparam logic [3:0] RegOrb  = 4'd0;
  localparam logic [3:0] RegOra  = 4'd1;
  localparam logic [3:0] RegDdrb = 4'd2;
  localparam logic [3:0] RegDdra = 4'd3;
  localparam logic [3:0] RegT1cl = 4'd4;
  localparam logic [3:0] RegT1ch = 4'd5;
  localparam logic [3:0] RegT1ll = 4'd6;
  localparam logic [3:0] RegT1lh = 4'd7;
  localparam logic [3:0] RegT2cl = 4'd8;
  localparam logic [3:0] RegT2ch = 4'd9;
  localparam logic [3:0] RegSr   = 4'd10;
  localparam logic [3:0] RegAcr  = 4'd11;
  localparam logic [3:0] RegPcr  = 4'd12;
  localparam logic [3:0] RegIfr  = 4'd13;
  localparam logic [3:0] RegIer  = 4'd14;
  localparam logic [3:0] RegOraNh = 4'd15;

  localparam logic [2:0] CfgAIn    = 3'd0;
  localparam logic [2:0] CfgAOut   = 3'd1;
  localparam logic [2:0] CfgAFloat = 3'd2;
  localparam logic [2:0] CfgBIn    = 3'd3;
  localparam logic [2:0] CfgBOut   = 3'd4;
  localparam logic [2:0] CfgBFloat = 3'd5;

  localparam int unsigned IfCa2 = 0;
  localparam int unsigned IfCa1 = 1;
  localparam int unsigned IfSr  = 2;
  localparam int unsigned IfCb2 = 3;
  localparam int unsigned IfCb1 = 4;
  localparam int unsigned IfT2  = 5;
  localparam int unsigned IfT1  = 6;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] reg_select;
    logic [7:0] write_data;
    logic [1:0] line_select;
    logic [7:0] pins_a_in;
    logic [7:0] pins_b_in;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_level;
    logic [7:0] port_b_level;
    logic       cb2_level;
    logic       shift_error;
  } rsp_t;

  typedef struct packed {
    logic [7:0] a_in;
    logic [7:0] a_out;
    logic [7:0] a_flt;
    logic [7:0] b_in;
    logic [7:0] b_out;
    logic [7:0] b_flt;
  } cfg_t;

endpackage

[src/via_if.sv]
interface via_req_if;
  logic        valid;
  logic        ready;
  via_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface via_rsp_if;
  logic        valid;
  logic        ready;
  via_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/via_cfg.sv]
module via_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i,
  output via_pkg::cfg_t  cfg_o
);
  via_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        via_pkg::CfgAIn:    cfg_q.a_in  <= cfg_data_i;
        via_pkg::CfgAOut:   cfg_q.a_out <= cfg_data_i;
        via_pkg::CfgAFloat: cfg_q.a_flt <= cfg_data_i;
        via_pkg::CfgBIn:    cfg_q.b_in  <= cfg_data_i;
        via_pkg::CfgBOut:   cfg_q.b_out <= cfg_data_i;
        via_pkg::CfgBFloat: cfg_q.b_flt <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

[src/via_exec.sv]
module via_exec (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  via_pkg::req_t req_i,
  input  via_pkg::cfg_t cfg_i,
  output via_pkg::rsp_t rsp_o
);
  logic [7:0]  ora_q, ora_d, orb_q, orb_d, ddra_q, ddra_d, ddrb_q, ddrb_d;
  logic [15:0] t1l_q, t1l_d, t1c_q, t1c_d, t2c_q, t2c_d;
  logic [7:0]  t2ll_q, t2ll_d, sr_q, sr_d, acr_q, acr_d, pcr_q, pcr_d;
  logic [6:0]  ifr_q, ifr_d, ier_q, ier_d;
  logic        t1a_q, t1a_d, t2a_q, t2a_d, cb2_q, cb2_d;
  logic [7:0]  pa_q, pa_d, pb_q, pb_d;
  logic [7:0]  rd, m, fl, un, da, db, d;
  logic        wr, err;
  logic [2:0]  mode;

  always_comb begin
    ora_d = ora_q; orb_d = orb_q; ddra_d = ddra_q; ddrb_d = ddrb_q;
    t1l_d = t1l_q; t1c_d = t1c_q; t2c_d = t2c_q; t2ll_d = t2ll_q;
    sr_d = sr_q; acr_d = acr_q; pcr_d = pcr_q; ifr_d = ifr_q; ier_d = ier_q;
    t1a_d = t1a_q; t2a_d = t2a_q; cb2_d = cb2_q; pa_d = pa_q; pb_d = pb_q;
    rd = '0; err = 1'b0; m = '0; fl = '0; un = '0; da = '0; db = '0;
    d = req_i.write_data;
    wr = (req_i.kind == via_pkg::KindWrite);
    mode = acr_q[4:2];
    case (req_i.kind)
      via_pkg::KindRead, via_pkg::KindWrite: begin
        case (req_i.reg_select)
          via_pkg::RegOrb: begin
            if (pcr_q[7:5] == 3'd0) ifr_d[via_pkg::IfCb2] = 1'b0;
            ifr_d[via_pkg::IfCb1] = 1'b0;
            if (wr) begin
              orb_d = d;
              m = ddrb_q & cfg_i.b_out;
              pb_d = (pb_q & ~m) | (d & m);
            end else begin
              rd = (orb_q & ddrb_q) | (~cfg_i.b_in & ~ddrb_q & cfg_i.b_flt)
                 | (~ddrb_q & cfg_i.b_in & pb_q);
            end
          end
          via_pkg::RegOra, via_pkg::RegOraNh: begin
            if (pcr_q[3:1] == 3'd0) ifr_d[via_pkg::IfCa2] = 1'b0;
            ifr_d[via_pkg::IfCa1] = 1'b0;
            if (wr) begin
              ora_d = d;
              m = ddra_q & cfg_i.a_out;
              pa_d = (pa_q & ~m) | (d & m);
            end else begin
              rd = (ora_q & ddra_q) | (~cfg_i.a_in & ~ddra_q & cfg_i.a_flt)
                 | (~ddra_q & cfg_i.a_in & pa_q);
            end
          end
          via_pkg::RegDdrb: begin
            if (wr) begin
              fl = ddrb_q & ~d & cfg_i.b_out;
              un = d & ~ddrb_q & cfg_i.b_out;
              pb_d = (((pb_q & ~fl) | (cfg_i.b_flt & fl)) & ~un) | (orb_q & un);
              ddrb_d = d;
            end else rd = ddrb_q;
          end
          via_pkg::RegDdra: begin
            if (wr) begin
              fl = ddra_q & ~d & cfg_i.a_out;
              un = d & ~ddra_q & cfg_i.a_out;
              pa_d = (((pa_q & ~fl) | (cfg_i.a_flt & fl)) & ~un) | (ora_q & un);
              ddra_d = d;
            end else rd = ddra_q;
          end
          via_pkg::RegT1cl: begin
            if (wr) t1l_d[7:0] = d;
            else begin
              ifr_d[via_pkg::IfT1] = 1'b0;
              rd = t1c_q[7:0];
            end
          end
          via_pkg::RegT1ll: begin
            if (wr) t1l_d[7:0] = d;
            else rd = t1l_q[7:0];
          end
          via_pkg::RegT1ch: begin
            if (wr) begin
              t1l_d[15:8] = d;
              ifr_d[via_pkg::IfT1] = 1'b0;
              t1c_d = {d, t1l_q[7:0]};
              if (!acr_q[6]) t1a_d = 1'b1;
            end else rd = t1c_q[15:8];
          end
          via_pkg::RegT1lh: begin
            if (wr) t1l_d[15:8] = d;
            else rd = t1l_q[15:8];
          end
          via_pkg::RegT2cl: begin
            if (wr) t2ll_d = d;
            else begin
              ifr_d[via_pkg::IfT2] = 1'b0;
              rd = t2c_q[7:0];
            end
          end
          via_pkg::RegT2ch: begin
            if (wr) begin
              t2c_d = {d, t2ll_q};
              ifr_d[via_pkg::IfT2] = 1'b0;
              t2a_d = 1'b1;
            end else rd = t2c_q[15:8];
          end
          via_pkg::RegSr: begin
            ifr_d[via_pkg::IfSr] = 1'b0;
            if (wr) begin
              sr_d = d;
              if (mode == 3'd6 && d == 8'd0) cb2_d = 1'b0;
            end else rd = sr_q;
          end
          via_pkg::RegAcr: begin
            if (wr) begin
              if (acr_q[4] && !d[4]) cb2_d = 1'b1;
              acr_d = d;
              if (d[4:2] == 3'd0) ifr_d[via_pkg::IfSr] = 1'b0;
            end else rd = acr_q;
          end
          via_pkg::RegPcr: begin
            if (wr) pcr_d = d;
            else rd = pcr_q;
          end
          via_pkg::RegIfr: begin
            if (wr) ifr_d = ifr_q & ~d[6:0];
            else rd = {|(ifr_q & ier_q), ifr_q};
          end
          default: begin
            if (wr) begin
              if (d[7]) ier_d = ier_q | d[6:0];
              else ier_d = ier_q & ~d[6:0];
            end else rd = {1'b1, ier_q};
          end
        endcase
      end
      via_pkg::KindTick: begin
        t1c_d = t1c_q - 16'd1;
        t2c_d = t2c_q - 16'd1;
        if (t1c_q == 16'd1) begin
          if (acr_q[6]) begin
            t1c_d = t1l_q;
            if (acr_q[7] && cfg_i.b_out[7]) pb_d[7] = ~pb_q[7];
            ifr_d[via_pkg::IfT1] = 1'b1;
          end else if (t1a_q) begin
            t1a_d = 1'b0;
            ifr_d[via_pkg::IfT1] = 1'b1;
          end
        end
        if (t2a_q && t2c_q == 16'd1) begin
          t2a_d = 1'b0;
          ifr_d[via_pkg::IfT2] = 1'b1;
        end
      end
      via_pkg::KindPulse: begin
        case (req_i.line_select)
          2'd0: ifr_d[via_pkg::IfCa1] = 1'b1;
          2'd1: ifr_d[via_pkg::IfCa2] = 1'b1;
          2'd2: ifr_d[via_pkg::IfCb1] = 1'b1;
          default: ifr_d[via_pkg::IfCb2] = 1'b1;
        endcase
      end
      via_pkg::KindShiftIn: begin
        if (mode == 3'd3) begin
          sr_d = d;
          ifr_d[via_pkg::IfSr] = 1'b1;
          ifr_d[via_pkg::IfCb1] = 1'b1;
        end else err = 1'b1;
      end
      via_pkg::KindShiftOut: begin
        if (mode == 3'd7) begin
          ifr_d[via_pkg::IfSr] = 1'b1;
          ifr_d[via_pkg::IfCb1] = 1'b1;
          cb2_d = sr_q[0];
          rd = sr_q;
        end else err = 1'b1;
      end
      via_pkg::KindPins: begin
        da = ddra_q & cfg_i.a_out;
        db = ddrb_q & cfg_i.b_out;
        pa_d = (pa_q & da) | (req_i.pins_a_in & ~da);
        pb_d = (pb_q & db) | (req_i.pins_b_in & ~db);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ora_q <= '0; orb_q <= '0; ddra_q <= '0; ddrb_q <= '0;
      t1l_q <= '0; t1c_q <= '0; t2c_q <= '0; t2ll_q <= '0;
      sr_q <= '0; acr_q <= '0; pcr_q <= '0; ifr_q <= '0; ier_q <= '0;
      t1a_q <= 1'b0; t2a_q <= 1'b0; cb2_q <= 1'b0; pa_q <= '0; pb_q <= '0;
    end else if (en_i) begin
      ora_q <= ora_d; orb_q <= orb_d; ddra_q <= ddra_d; ddrb_q <= ddrb_d;
      t1l_q <= t1l_d; t1c_q <= t1c_d; t2c_q <= t2c_d; t2ll_q <= t2ll_d;
      sr_q <= sr_d; acr_q <= acr_d; pcr_q <= pcr_d; ifr_q <= ifr_d; ier_q <= ier_d;
      t1a_q <= t1a_d; t2a_q <= t2a_d; cb2_q <= cb2_d; pa_q <= pa_d; pb_q <= pb_d;
    end
  end

  assign rsp_o.read_data    = rd;
  assign rsp_o.irq          = |(ifr_d & ier_d);
  assign rsp_o.port_a_level = pa_d;
  assign rsp_o.port_b_level = pb_d;
  assign rsp_o.cb2_level    = cb2_d;
  assign rsp_o.shift_error  = err;
endmodule

[src/versatile_interface_adapter_core.sv]
// Interface adapter with two ports, two timers, a shift register and interrupt
// logic. One request (register access, tick, line pulse, shift or pin update) is
// taken per clock while the skid register is empty; its result is registered in
// the output register. A one-entry skid register behind it lets one more request in
// while the result stalls; then requests wait until the output register drains.
// Pin masks and float levels are written through the configuration port while
// idle; the user must keep to this, as the block itself does not enforce it.
module versatile_interface_adapter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  via_req_if.sink    req_if,
  via_rsp_if.source  rsp_if
);
  via_pkg::cfg_t cfg;
  via_pkg::rsp_t rsp, out_q, skid_q;
  logic out_vld_q, skid_vld_q, acc;

  via_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );

  assign req_if.ready = !skid_vld_q;
  assign acc = req_if.valid && req_if.ready;

  via_exec u_exec (
    .clk_i, .rst_ni, .en_i(acc), .req_i(req_if.payload), .cfg_i(cfg), .rsp_o(rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || rsp_if.ready) begin
        out_vld_q <= skid_vld_q || acc;
        skid_vld_q <= 1'b0;
      end else if (acc) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || rsp_if.ready) begin
      out_q <= skid_vld_q ? skid_q : rsp;
    end else if (acc) begin
      skid_q <= rsp;
    end
  end

  assign rsp_if.valid = out_vld_q;
  assign rsp_if.payload = out_q;
endmodule

[tb/tb_versatile_interface_adapter_core.sv]
module tb_versatile_interface_adapter_core;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned ItemsPerPhase = 400;

  typedef struct {
    via_pkg::req_t r;
    bit            typed;
    via_pkg::rsp_t want;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  via_req_if req_if ();
  via_rsp_if rsp_if ();

  versatile_interface_adapter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .req_if     (req_if.sink),
    .rsp_if     (rsp_if.source)
  );

  // Shadow copy of the adapter state.
  logic [7:0]  a_imask, a_omask, a_flt, b_imask, b_omask, b_flt;
  logic [7:0]  ora, orb, ddra, ddrb, t2ll, sreg, acr, pcr;
  logic [15:0] t1l, t1c, t2c, pins;
  logic [6:0]  ifr, ier;
  logic        t1_arm, t2_arm, cb2;

  via_pkg::rsp_t pending_rsps[$];
  int unsigned errs;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void shadow_reset();
    {a_imask, a_omask, a_flt, b_imask, b_omask, b_flt} = {6{8'hFF}};
    {ora, orb, ddra, ddrb, t2ll, sreg, acr, pcr} = '0;
    {t1l, t1c, t2c, pins} = '0;
    ifr = '0;
    ier = '0;
    {t1_arm, t2_arm, cb2} = '0;
  endfunction

  function automatic void shadow_cfg(logic [2:0] idx, logic [7:0] v);
    case (idx)
      via_pkg::CfgAIn:    a_imask = v;
      via_pkg::CfgAOut:   a_omask = v;
      via_pkg::CfgAFloat: a_flt = v;
      via_pkg::CfgBIn:    b_imask = v;
      via_pkg::CfgBOut:   b_omask = v;
      via_pkg::CfgBFloat: b_flt = v;
      default: ;
    endcase
  endfunction

  function automatic void drive_pa(logic [7:0] sel, logic [7:0] val);
    logic [7:0] m;
    m = sel & a_omask;
    pins[7:0] = (pins[7:0] & ~m) | (val & m);
  endfunction

  function automatic void drive_pb(logic [7:0] sel, logic [7:0] val);
    logic [7:0] m;
    m = sel & b_omask;
    pins[15:8] = (pins[15:8] & ~m) | (val & m);
  endfunction

  function automatic void count_down();
    logic t1_exp, t2_exp;
    t1_exp = (t1c == 16'd1);
    t2_exp = (t2c == 16'd1);
    t1c = t1c - 16'd1;
    if (t1_exp) begin
      if (acr[6]) begin
        t1c = t1l;
        if (acr[7] && b_omask[7]) pins[15] = ~pins[15];
        ifr[via_pkg::IfT1] = 1'b1;
      end else if (t1_arm) begin
        t1_arm = 1'b0;
        ifr[via_pkg::IfT1] = 1'b1;
      end
    end
    if (t2_arm && t2_exp) begin
      t2_arm = 1'b0;
      ifr[via_pkg::IfT2] = 1'b1;
    end
    t2c = t2c - 16'd1;
  endfunction

  function automatic logic [7:0] reg_access(logic wr, logic [3:0] rs, logic [7:0] d);
    logic [7:0] r, fl, un;
    r = '0;
    case (rs)
      via_pkg::RegOrb: begin
        if (pcr[7:5] == 3'd0) ifr[via_pkg::IfCb2] = 1'b0;
        ifr[via_pkg::IfCb1] = 1'b0;
        if (wr) begin
          orb = d;
          drive_pb(ddrb, orb);
        end else begin
          r = (orb & ddrb) | (~ddrb & ~b_imask & b_flt)
            | (~ddrb & b_imask & pins[15:8]);
        end
      end
      via_pkg::RegOra, via_pkg::RegOraNh: begin
        if (pcr[3:1] == 3'd0) ifr[via_pkg::IfCa2] = 1'b0;
        ifr[via_pkg::IfCa1] = 1'b0;
        if (wr) begin
          ora = d;
          drive_pa(ddra, ora);
        end else begin
          r = (ora & ddra) | (~ddra & ~a_imask & a_flt)
            | (~ddra & a_imask & pins[7:0]);
        end
      end
      via_pkg::RegDdrb: begin
        if (wr) begin
          fl = ddrb & ~d;
          un = d & ~ddrb;
          drive_pb(fl, b_flt);
          ddrb = d;
          drive_pb(un, orb);
        end else r = ddrb;
      end
      via_pkg::RegDdra: begin
        if (wr) begin
          fl = ddra & ~d;
          un = d & ~ddra;
          drive_pa(fl, a_flt);
          ddra = d;
          drive_pa(un, ora);
        end else r = ddra;
      end
      via_pkg::RegT1cl, via_pkg::RegT1ll: begin
        if (wr) t1l[7:0] = d;
        else if (rs == via_pkg::RegT1cl) begin
          ifr[via_pkg::IfT1] = 1'b0;
          r = t1c[7:0];
        end else r = t1l[7:0];
      end
      via_pkg::RegT1ch: begin
        if (wr) begin
          t1l[15:8] = d;
          ifr[via_pkg::IfT1] = 1'b0;
          t1c = t1l;
          if (!acr[6]) t1_arm = 1'b1;
        end else r = t1c[15:8];
      end
      via_pkg::RegT1lh: begin
        if (wr) t1l[15:8] = d;
        else r = t1l[15:8];
      end
      via_pkg::RegT2cl: begin
        if (wr) t2ll = d;
        else begin
          ifr[via_pkg::IfT2] = 1'b0;
          r = t2c[7:0];
        end
      end
      via_pkg::RegT2ch: begin
        if (wr) begin
          t2c = {d, t2ll};
          ifr[via_pkg::IfT2] = 1'b0;
          t2_arm = 1'b1;
        end else r = t2c[15:8];
      end
      via_pkg::RegSr: begin
        if (wr) sreg = d;
        ifr[via_pkg::IfSr] = 1'b0;
        if (acr[4:2] == 3'd6 && wr && sreg == 8'd0) cb2 = 1'b0;
        if (!wr) r = sreg;
      end
      via_pkg::RegAcr: begin
        if (wr) begin
          if (acr[4] != d[4] && !d[4]) cb2 = 1'b1;
          acr = d;
          if (acr[4:2] == 3'd0) ifr[via_pkg::IfSr] = 1'b0;
        end else r = acr;
      end
      via_pkg::RegPcr: begin
        if (wr) pcr = d;
        else r = pcr;
      end
      via_pkg::RegIfr: begin
        if (wr) ifr = ifr & ~d[6:0];
        else r = {|(ifr & ier), ifr};
      end
      default: begin
        if (wr) begin
          if (d[7]) ier = ier | d[6:0];
          else ier = ier & ~d[6:0];
        end else r = {1'b1, ier};
      end
    endcase
    return r;
  endfunction

  function automatic via_pkg::rsp_t predict_response(via_pkg::req_t q);
    via_pkg::rsp_t o;
    logic [7:0]    rd, da, db;
    logic          err;
    logic [2:0]    mode;
    rd = '0;
    err = 1'b0;
    mode = acr[4:2];
    case (via_pkg::kind_e'(q.kind))
      via_pkg::KindRead:  rd = reg_access(1'b0, q.reg_select, q.write_data);
      via_pkg::KindWrite: void'(reg_access(1'b1, q.reg_select, q.write_data));
      via_pkg::KindTick:  count_down();
      via_pkg::KindPulse: begin
        case (q.line_select)
          2'd0: ifr[via_pkg::IfCa1] = 1'b1;
          2'd1: ifr[via_pkg::IfCa2] = 1'b1;
          2'd2: ifr[via_pkg::IfCb1] = 1'b1;
          default: ifr[via_pkg::IfCb2] = 1'b1;
        endcase
      end
      via_pkg::KindShiftIn: begin
        if (mode == 3'd3) begin
          sreg = q.write_data;
          ifr[via_pkg::IfSr] = 1'b1;
          ifr[via_pkg::IfCb1] = 1'b1;
        end else err = 1'b1;
      end
      via_pkg::KindShiftOut: begin
        if (mode == 3'd7) begin
          ifr[via_pkg::IfSr] = 1'b1;
          ifr[via_pkg::IfCb1] = 1'b1;
          cb2 = sreg[0];
          rd = sreg;
        end else err = 1'b1;
      end
      via_pkg::KindPins: begin
        da = ddra & a_omask;
        db = ddrb & b_omask;
        pins = {(pins[15:8] & db) | (q.pins_b_in & ~db),
                (pins[7:0] & da) | (q.pins_a_in & ~da)};
      end
      default: ;
    endcase
    o.read_data = rd;
    o.irq = |(ifr & ier);
    o.port_a_level = pins[7:0];
    o.port_b_level = pins[15:8];
    o.cb2_level = cb2;
    o.shift_error = err;
    return o;
  endfunction

  function automatic via_pkg::req_t mk(via_pkg::kind_e k, logic [3:0] rs, logic [7:0] d,
                                       logic [1:0] ln, logic [7:0] pa, logic [7:0] pb);
    via_pkg::req_t q;
    q.kind = k;
    q.reg_select = rs;
    q.write_data = d;
    q.line_select = ln;
    q.pins_a_in = pa;
    q.pins_b_in = pb;
    return q;
  endfunction

  function automatic via_pkg::req_t random_request();
    via_pkg::req_t q;
    int unsigned   sel;
    q = via_pkg::req_t'({1'($urandom), $urandom});
    sel = $urandom_range(99);
    if (sel < 25) q.kind = via_pkg::KindWrite;
    else if (sel < 45) q.kind = via_pkg::KindRead;
    else if (sel < 75) q.kind = via_pkg::KindTick;
    else if (sel < 82) q.kind = via_pkg::KindPulse;
    else if (sel < 88) q.kind = via_pkg::KindShiftIn;
    else if (sel < 94) q.kind = via_pkg::KindShiftOut;
    else if (sel < 99) q.kind = via_pkg::KindPins;
    else q.kind = via_pkg::KindNone;
    // Small timer values let the counters expire within a few ticks.
    if ($urandom_range(1) == 0) q.write_data = 8'($urandom_range(3));
    if (q.kind == via_pkg::KindWrite && q.reg_select == via_pkg::RegAcr
        && $urandom_range(1) == 0) begin
      case ($urandom_range(2))
        0: q.write_data[4:2] = 3'd3;
        1: q.write_data[4:2] = 3'd6;
        default: q.write_data[4:2] = 3'd7;
      endcase
    end
    return q;
  endfunction

  task automatic send_request(via_pkg::req_t q, bit typed, via_pkg::rsp_t want);
    via_pkg::rsp_t exp_rsp;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= q;
    do @(posedge clk_i); while (!req_if.ready);
    exp_rsp = predict_response(q);
    pending_rsps.push_back(typed ? want : exp_rsp);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    shadow_cfg(idx, v);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    via_pkg::rsp_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_rsps.size() == 0) begin
        $error("unexpected response %h", rsp_if.payload);
        errs++;
      end else begin
        want = pending_rsps.pop_front();
        if (rsp_if.payload.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, rsp_if.payload.read_data);
          errs++;
        end
        if (rsp_if.payload.irq !== want.irq) begin
          $error("irq: expected %b, got %b", want.irq, rsp_if.payload.irq);
          errs++;
        end
        if (rsp_if.payload.port_a_level !== want.port_a_level) begin
          $error("port_a_level: expected %h, got %h", want.port_a_level,
                 rsp_if.payload.port_a_level);
          errs++;
        end
        if (rsp_if.payload.port_b_level !== want.port_b_level) begin
          $error("port_b_level: expected %h, got %h", want.port_b_level,
                 rsp_if.payload.port_b_level);
          errs++;
        end
        if (rsp_if.payload.cb2_level !== want.cb2_level) begin
          $error("cb2_level: expected %b, got %b", want.cb2_level, rsp_if.payload.cb2_level);
          errs++;
        end
        if (rsp_if.payload.shift_error !== want.shift_error) begin
          $error("shift_error: expected %b, got %b", want.shift_error,
                 rsp_if.payload.shift_error);
          errs++;
        end
      end
    end
    if (rst_ni) rsp_if.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    row_t          rows[$];
    logic [7:0]    cfg_val[6];
    int unsigned   phase;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    errs = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_reset();

    rows.push_back('{mk(via_pkg::KindRead, via_pkg::RegOrb, 8'h00, 2'd0, 8'h00, 8'h00), 1'b1,
                     via_pkg::rsp_t'({8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0})});
    rows.push_back('{mk(via_pkg::KindRead, via_pkg::RegIer, 8'hFF, 2'd0, 8'h00, 8'h00), 1'b1,
                     via_pkg::rsp_t'({8'h80, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0})});
    rows.push_back('{mk(via_pkg::KindShiftIn, via_pkg::RegOrb, 8'hA5, 2'd0, 8'h00, 8'h00),
                     1'b1, via_pkg::rsp_t'({8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1})});
    rows.push_back('{mk(via_pkg::KindShiftOut, via_pkg::RegOrb, 8'h00, 2'd0, 8'h00, 8'h00),
                     1'b1, via_pkg::rsp_t'({8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1})});
    rows.push_back('{mk(via_pkg::KindNone, via_pkg::RegIer, 8'hFF, 2'd3, 8'hFF, 8'hFF), 1'b1,
                     via_pkg::rsp_t'({8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0})});
    rows.push_back('{mk(via_pkg::KindPins, via_pkg::RegOrb, 8'h00, 2'd0, 8'hFF, 8'hFF),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindRead, via_pkg::RegOraNh, 8'h00, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindWrite, via_pkg::RegDdra, 8'hFF, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindWrite, via_pkg::RegOra, 8'h5A, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindWrite, via_pkg::RegDdrb, 8'hF0, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindWrite, via_pkg::RegIer, 8'hFF, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindWrite, via_pkg::RegAcr, 8'hC0, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindWrite, via_pkg::RegT1cl, 8'h02, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindWrite, via_pkg::RegT1ch, 8'h00, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindTick, via_pkg::RegOrb, 8'h00, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindTick, via_pkg::RegOrb, 8'h00, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindRead, via_pkg::RegIfr, 8'h00, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindWrite, via_pkg::RegT2cl, 8'h00, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindWrite, via_pkg::RegT2ch, 8'h00, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindTick, via_pkg::RegOrb, 8'h00, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    for (int l = 0; l < 4; l++) begin
      rows.push_back('{mk(via_pkg::KindPulse, via_pkg::RegOrb, 8'h00, 2'(l), 8'h00, 8'h00),
                       1'b0, '0});
    end
    rows.push_back('{mk(via_pkg::KindWrite, via_pkg::RegAcr, 8'h0C, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindShiftIn, via_pkg::RegOrb, 8'hFF, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindWrite, via_pkg::RegAcr, 8'h1C, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});
    rows.push_back('{mk(via_pkg::KindShiftOut, via_pkg::RegOrb, 8'h00, 2'd0, 8'h00, 8'h00),
                     1'b0, '0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (phase != 0) begin
        drain();
        for (int i = 0; i < 6; i++) begin
          case (phase)
            1: cfg_val[i] = 8'h00;
            2: cfg_val[i] = 8'($urandom);
            default: cfg_val[i] = 8'hFF;
          endcase
          write_cfg(3'(i), cfg_val[i]);
        end
        cfg_we_i <= 1'b0;
      end else begin
        foreach (rows[i]) send_request(rows[i].r, rows[i].typed, rows[i].want);
      end
      for (int n = 0; n < ItemsPerPhase; n++) send_request(random_request(), 1'b0, '0);
    end

    drain();
    if (errs == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
